/* hw/rtl/lrup_pkg.sv */
package lrup_pkg;

    // fixed field widths of the stream payloads
    localparam int CMD_W    = 2;
    localparam int PAGE_W   = 20;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming transaction
        logic lookup;  // register the tag compare
        logic commit;  // apply the update and load the result register
    } dp_cmd_t;

endpackage

/* hw/rtl/lrup_ctrl.sv */
module lrup_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output lrup_pkg::dp_cmd_t dp_cmd
);
    import lrup_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        dp_cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                dp_cmd.lookup = 1'b1;
                state_next    = S_UPDATE;
            end
            S_UPDATE:
            begin
                // hold until the result register can take a new result
                if (out_free)
                begin
                    dp_cmd.commit  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/lrup_datapath.sv */
module lrup_datapath
#(
    parameter int ENTRIES   = 8,
    parameter int PAGE_BITS = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrup_pkg::dp_cmd_t             dp_cmd,
    input  logic [lrup_pkg::CMD_W-1:0]    in_cmd,
    input  logic [lrup_pkg::PAGE_W-1:0]   in_page_id,
    output logic [lrup_pkg::PAGE_W-1:0]   victim_page,
    output logic                          victim_valid,
    output logic [lrup_pkg::STATUS_W-1:0] status,
    output logic [lrup_pkg::COUNT_W-1:0]  resident_count
);
    import lrup_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    logic [CMD_W-1:0]     cmd_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [PAGE_BITS-1:0] tags_reg [ENTRIES];
    logic [PAGE_BITS-1:0] tags_next [ENTRIES];
    logic [PAGE_BITS-1:0] tags_up [ENTRIES];
    logic [ENTRIES-1:0]   match_reg;
    logic [ENTRIES-1:0]   match_next;
    logic [ENTRIES-1:0]   after;
    logic                 hit;

    logic [PAGE_W-1:0]    victim_page_reg;
    logic [PAGE_W-1:0]    victim_page_next;
    logic                 victim_valid_reg;
    logic                 victim_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [COUNT_W-1:0]   resident_count_reg;

    // neighbor above each slot, for closing a gap
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_up
        if (g < ENTRIES - 1)
        begin : g_mid
            assign tags_up[g] = tags_reg[g+1];
        end
        else
        begin : g_top
            assign tags_up[g] = tags_reg[g];
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = (CW'(i) < count_reg) && (tags_reg[i] == page_reg);
        end
    end

    // slots at or above the matching slot
    always_comb
    begin
        after[0] = match_reg[0];
        for (int i = 1; i < ENTRIES; i++)
        begin
            after[i] = after[i-1] | match_reg[i];
        end
    end

    assign hit = |match_reg;

    always_comb
    begin
        tags_next         = tags_reg;
        count_next        = count_reg;
        victim_page_next  = '0;
        victim_valid_next = 1'b0;
        status_next       = ST_OK;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (hit)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (CW'(i) == count_reg)
                        begin
                            tags_next[i] = page_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_TOUCH:
            begin
                if (!hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    // close the gap and place the page at the most recent end
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (after[i])
                        begin
                            if (CW'(i + 1) == count_reg)
                            begin
                                tags_next[i] = page_reg;
                            end
                            else
                            begin
                                tags_next[i] = tags_up[i];
                            end
                        end
                    end
                end
            end
            CMD_EVICT:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    victim_page_next  = PAGE_W'(tags_reg[0]);
                    victim_valid_next = 1'b1;
                    tags_next         = tags_up;
                    count_next        = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg  <= in_cmd;
            page_reg <= PAGE_BITS'(in_page_id);
        end
        if (dp_cmd.lookup)
        begin
            match_reg <= match_next;
        end
        if (dp_cmd.commit)
        begin
            tags_reg           <= tags_next;
            victim_page_reg    <= victim_page_next;
            victim_valid_reg   <= victim_valid_next;
            status_reg         <= status_next;
            resident_count_reg <= COUNT_W'(count_next);
        end
    end

    assign victim_page    = victim_page_reg;
    assign victim_valid   = victim_valid_reg;
    assign status         = status_reg;
    assign resident_count = resident_count_reg;

endmodule

/* hw/rtl/lru_page_replacement_top.sv */
// lru page replacement table: holds up to ENTRIES resident page numbers in
// recency order and answers every input transaction with exactly one result.
// s_tdata carries cmd (insert, touch, evict) and page_id; m_tdata returns the
// evicted page, its valid flag, a status code and the resident count after
// the item. an item passes three steps (capture at the accepting edge, parallel
// tag compare, shift/commit), and its result is presented from the output
// register that the commit step loads; the controller handles one item at a
// time. the result sits in an output register, so the next item is accepted
// while it waits, and the commit step holds only if the previous result has
// not yet been taken. the tag slots need no clearing after reset: only slots
// below the resident count are ever compared or read.
module lru_page_replacement_top
#(
    parameter int ENTRIES   = 8,
    parameter int PAGE_BITS = 20
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lrup_pkg::IN_DATA_W-1:0]     s_tdata,   // cmd[1:0], page_id[21:2], zero pad
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrup_pkg::OUT_DATA_W-1:0]    m_tdata    // victim_page[19:0], victim_valid[20],
                                                          // status[23:21], resident_count[27:24]
);
    import lrup_pkg::*;

    dp_cmd_t             dp_cmd;
    logic [PAGE_W-1:0]   victim_page;
    logic                victim_valid;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  resident_count;

    // sequencing: capture, compare, commit
    lrup_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    // tag slots, compare and recency shift
    lrup_datapath
    #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .in_cmd         (s_tdata[CMD_W-1:0]),
        .in_page_id     (s_tdata[CMD_W+PAGE_W-1:CMD_W]),
        .victim_page    (victim_page),
        .victim_valid   (victim_valid),
        .status         (status),
        .resident_count (resident_count)
    );

    // result packing, highest field first
    assign m_tdata = {4'b0000, resident_count, status, victim_valid, victim_page};

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import lrup_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int ITEM_TARGET = 1900;
    localparam int POOL_SIZE   = 12;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 600;

    // code 3 is not a command; the block answers it with an empty ok result
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    // one expected result, fields as they leave on m_tdata
    typedef struct {
        logic [PAGE_W-1:0]   victim_page;
        logic                victim_valid;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  resident_count;
    } lru_result_t;

    // tracks the resident pages in recency order and the results still owed
    class lru_scoreboard;
        logic [PAGE_W-1:0] recency_q[$];   // front is the least recent page
        lru_result_t       owed_q[$];
        int                errors;
        int                accepted;

        function int find_page(logic [PAGE_W-1:0] page);
            for (int i = 0; i < recency_q.size(); i++)
                if (recency_q[i] == page)
                    return i;
            return -1;
        endfunction

        // predict the result of one accepted transaction and queue it
        function void note_item(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
            lru_result_t res;
            int          slot;
            res.victim_page  = '0;
            res.victim_valid = 1'b0;
            res.status       = ST_OK;
            slot             = find_page(page);
            case (cmd)
                CMD_INSERT:
                begin
                    // duplicate wins over full
                    if (slot >= 0)
                        res.status = ST_DUPLICATE;
                    else if (recency_q.size() >= TABLE_DEPTH)
                        res.status = ST_FULL;
                    else
                        recency_q.push_back(page);
                end
                CMD_TOUCH:
                begin
                    if (slot < 0)
                        res.status = ST_NOT_FOUND;
                    else
                    begin
                        recency_q.delete(slot);
                        recency_q.push_back(page);
                    end
                end
                CMD_EVICT:
                begin
                    if (recency_q.size() == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        res.victim_page  = recency_q.pop_front();
                        res.victim_valid = 1'b1;
                    end
                end
                default: ;
            endcase
            res.resident_count = COUNT_W'(recency_q.size());
            owed_q.push_back(res);
            accepted++;
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v)
            begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            lru_result_t exp_r;
            if (owed_q.size() == 0)
            begin
                $display("%0t ns: result %h with nothing expected, expected none, actual %h",
                         $time, data, data);
                errors++;
                return;
            end
            exp_r = owed_q.pop_front();
            compare_field("victim_page", exp_r.victim_page, data[PAGE_W-1:0]);
            compare_field("victim_valid", exp_r.victim_valid, data[PAGE_W]);
            compare_field("status", exp_r.status, data[PAGE_W+STATUS_W:PAGE_W+1]);
            compare_field("resident_count", exp_r.resident_count,
                          data[PAGE_W+STATUS_W+COUNT_W:PAGE_W+STATUS_W+1]);
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // cmd[1:0], page_id[21:2], zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // victim_page[19:0], victim_valid[20],
                                       // status[23:21], resident_count[27:24]

    lru_scoreboard     sb;
    logic [PAGE_W-1:0] page_pool[POOL_SIZE];

    lru_page_replacement_top #(
        .ENTRIES   (TABLE_DEPTH),
        .PAGE_BITS (PAGE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // offer one transaction and hold it until the block takes it;
    // valid stays high on return so back-to-back items need no toggle
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, page, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(cmd, page);
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // mostly pages from a small pool so touches hit and inserts collide,
    // now and then a fresh page from the whole range
    function automatic logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 99) < 85)
            return page_pool[$urandom_range(0, POOL_SIZE - 1)];
        return PAGE_W'($urandom);
    endfunction

    // check every result transaction as it leaves the block
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: random ready/stall pattern, one long hold-off once the
    // stream is well under way so the block backs up and drops s_tready
    initial
    begin : receiver
        bit long_done;
        int run;
        long_done = 1'b0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_done && sb.accepted >= HOLD_AFTER)
            begin
                long_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                // occasional long stretch with no stalls
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
                m_tready <= 1'b1;
                repeat (run) @(posedge clk);
                run = $urandom_range(0, 6);
                if (run > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int               done_items;
        int               burst_left;
        int               phase_left;
        int               pick;
        bit               filling;
        logic [CMD_W-1:0] cmd;

        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            page_pool[i] = PAGE_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table corners
        send_item(CMD_EVICT, 20'h5a5a5);              // evict from empty table
        send_item(CMD_TOUCH, 20'h00000);              // touch on empty table
        // page extremes and duplicate detection
        send_item(CMD_INSERT, 20'h00000);
        send_item(CMD_INSERT, 20'hfffff);
        send_item(CMD_INSERT, 20'hfffff);             // duplicate insert
        for (int i = 1; i <= 6; i++)
            send_item(CMD_INSERT, PAGE_W'(i * 20'h2aaab));
        send_item(CMD_INSERT, 20'h12345);             // insert into full table
        send_item(CMD_INSERT, 20'h00000);             // duplicate beats full
        send_item(CMD_TOUCH, PAGE_W'(6 * 20'h2aaab)); // touch most recent
        send_item(CMD_TOUCH, 20'h00000);              // touch least recent
        send_item(CMD_TOUCH, 20'h54321);              // touch absent page
        send_item(CMD_IGNORED, 20'hfffff);            // unused command code
        repeat (8)
            send_item(CMD_EVICT, 20'hfffff);          // drain in lru order
        idle_sender(5);

        // random: alternate fill and drain phases so the table swings
        // between empty and full with touches hitting resident pages
        done_items = 0;
        burst_left = $urandom_range(1, 20);
        phase_left = $urandom_range(60, 140);
        filling    = 1'b1;
        while (done_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_IGNORED;
            else if (pick < (filling ? 55 : 22))
                cmd = CMD_INSERT;
            else if (pick < (filling ? 85 : 52))
                cmd = CMD_TOUCH;
            else
                cmd = CMD_EVICT;
            send_item(cmd, pick_page());
            if (cmd != CMD_IGNORED)
                done_items++;
            if (done_items % 150 == 0)
                page_pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_W'($urandom);
            phase_left--;
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(60, 140);
            end
            burst_left--;
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(0, 7));
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                         : $urandom_range(1, 20);
            end
        end
        s_tvalid <= 1'b0;

        // wait for every owed result, then a few more cycles for strays
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
